// ===== hdl/alu8080_pkg.sv =====
// shared types, command codes and flag packing for the 8080 immediate alu
package alu8080_pkg;

    typedef enum logic [2:0] {
        CMD_DCR = 3'd0,
        CMD_ANI = 3'd1,
        CMD_ADI = 3'd2,
        CMD_ACI = 3'd3,
        CMD_CPI = 3'd4
    } cmd_t;

    // flag bit positions in the packed flag byte
    localparam int unsigned FLAG_CY_BIT = 0;
    localparam int unsigned FLAG_P_BIT  = 2;
    localparam int unsigned FLAG_AC_BIT = 4;
    localparam int unsigned FLAG_Z_BIT  = 6;
    localparam int unsigned FLAG_S_BIT  = 7;

    typedef struct packed {
        logic [7:0] acc;
        logic       cy;
        logic       p;
        logic       ac;
        logic       z;
        logic       s;
    } alu_state_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic [7:0] flag_byte;
    } alu_result_t;

    function automatic logic [7:0] pack_flags(input alu_state_t st);
        logic [7:0] f;
        f = 8'h00;
        f[FLAG_CY_BIT] = st.cy;
        f[FLAG_P_BIT]  = st.p;
        f[FLAG_AC_BIT] = st.ac;
        f[FLAG_Z_BIT]  = st.z;
        f[FLAG_S_BIT]  = st.s;
        return f;
    endfunction

endpackage

// ===== hdl/alu_8080_immediate_flags.sv =====
// top level of the 8080 immediate alu with accumulator, flags and output skid buffer
//
// one command per transfer: decrement (dcr), and immediate (ani), add immediate (adi),
// add with carry (aci) and compare (cpi) against an internal accumulator and five flags
// (s z ac p cy). each accepted command yields exactly one result: the result byte and
// the packed flag byte (bit7 s, bit6 z, bit4 ac, bit2 p, bit0 cy, other bits zero).
// a new command is taken every clock while in_ready is high, for a throughput of one command
// per cycle; each result is registered in the output register, or in the skid stage behind it.
// the combinational 8-bit add and flag logic updates the accumulator and flags at the input
// transfer. an output register plus a one-entry skid stage lets one more command in while a
// result waits; in_ready drops only once both are full. codes 5 to 7 change nothing and
// report the accumulator and current flags. reset clears the accumulator and all flags.
module alu_8080_immediate_flags (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] operand,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result_byte,
    output logic [7:0] flag_byte
);

    // architectural state
    alu8080_pkg::alu_state_t  state_reg;
    alu8080_pkg::alu_state_t  state_next;
    alu8080_pkg::alu_result_t new_result;

    // output register and skid stage
    alu8080_pkg::alu_result_t out_data_reg;
    alu8080_pkg::alu_result_t skid_data_reg;
    logic                     out_valid_reg;
    logic                     skid_valid_reg;

    logic in_xfer;
    logic out_load;

    alu8080_core u_core (
        .command    (command),
        .operand    (operand),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (new_result)
    );

    assign in_ready = ~skid_valid_reg;
    assign in_xfer  = in_valid & in_ready;
    // output register can take new data when empty or being drained
    assign out_load = ~out_valid_reg | out_ready;

    // accumulator and flags advance on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // valid bits of the output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= skid_valid_reg | in_xfer;
            skid_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload: skid entry is older, so it moves out first
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_xfer)
            begin
                out_data_reg <= new_result;
            end
        end
        else if (in_xfer)
        begin
            skid_data_reg <= new_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = out_data_reg.result_byte;
    assign flag_byte   = out_data_reg.flag_byte;

    // skid stage only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    // a transfer into a stalled output lands in the skid stage
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("stalled transfer not captured by skid stage");

    // unused flag bits stay clear on every presented result
    a_flag_pad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flag_byte[5] == 1'b0 && flag_byte[3] == 1'b0 && flag_byte[1] == 1'b0))
        else $error("reserved flag bit set");

    // the skid stage drains whenever the output register is drained
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not moved to output register");

endmodule

// ===== hdl/alu8080_core.sv =====
// combinational datapath: one alu command against the current accumulator and flags
module alu8080_core (
    input  logic [2:0]                command,
    input  logic [7:0]                operand,
    input  alu8080_pkg::alu_state_t   state_cur,
    output alu8080_pkg::alu_state_t   state_next,
    output alu8080_pkg::alu_result_t  result
);

    logic [7:0] dec_value;
    logic [7:0] and_value;
    logic       cin;
    logic [8:0] sum;
    logic [4:0] sum_low;
    logic [8:0] diff;
    logic [4:0] diff_low;
    logic [7:0] szp_value;
    logic [7:0] res_value;

    assign dec_value = operand - 8'd1;
    assign and_value = state_cur.acc & operand;
    assign cin       = (alu8080_pkg::cmd_t'(command) == alu8080_pkg::CMD_ACI) ? state_cur.cy
                                                                               : 1'b0;
    assign sum       = {1'b0, state_cur.acc} + {1'b0, operand} + {8'd0, cin};
    assign sum_low   = {1'b0, state_cur.acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
    assign diff      = {1'b0, state_cur.acc} - {1'b0, operand};
    assign diff_low  = {1'b0, state_cur.acc[3:0]} - {1'b0, operand[3:0]};

    always_comb
    begin
        state_next = state_cur;
        szp_value  = state_cur.acc;
        res_value  = state_cur.acc;
        case (alu8080_pkg::cmd_t'(command))
            alu8080_pkg::CMD_DCR:
            begin
                szp_value     = dec_value;
                res_value     = dec_value;
                state_next.ac = (operand[3:0] != 4'd0);
            end
            alu8080_pkg::CMD_ANI:
            begin
                szp_value      = and_value;
                res_value      = and_value;
                state_next.acc = and_value;
                state_next.cy  = 1'b0;
                state_next.ac  = 1'b0;
            end
            alu8080_pkg::CMD_ADI, alu8080_pkg::CMD_ACI:
            begin
                szp_value      = sum[7:0];
                res_value      = sum[7:0];
                state_next.acc = sum[7:0];
                state_next.cy  = sum[8];
                state_next.ac  = sum_low[4];
            end
            alu8080_pkg::CMD_CPI:
            begin
                szp_value     = diff[7:0];
                state_next.cy = diff[8];
                state_next.ac = diff_low[4];
            end
            default:
            begin
                szp_value = state_cur.acc;
            end
        endcase
        // unused codes keep every flag, so sign, zero and parity are only set for the codes above
        if (command <= 3'(alu8080_pkg::CMD_CPI))
        begin
            state_next.z = (szp_value == 8'd0);
            state_next.s = szp_value[7];
            state_next.p = ~^szp_value;
        end
    end

    assign result.result_byte = res_value;
    assign result.flag_byte   = alu8080_pkg::pack_flags(state_next);

endmodule

// ===== dv/alu_8080_immediate_flags_test.sv =====
// self-checking testbench for the 8080 immediate alu with accumulator and packed flags
module alu_8080_immediate_flags_test;

    // command codes that the block must ignore
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    localparam int RANDOM_ITEMS    = 1000;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int PAUSE_ITEMS     = 10;
    localparam int FULL_RATE_ITEMS = 270;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int MAX_REPORTS     = 10;

    // one expected result, kept with the command that caused it for the report
    typedef struct packed {
        logic [2:0]               cmd;
        logic [7:0]               data;
        alu8080_pkg::alu_result_t res;
    } alu_expect_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [2:0] command   = alu8080_pkg::CMD_DCR;
    logic [7:0] operand   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] result_byte;
    logic [7:0] flag_byte;

    // predictor copy of the accumulator and flags, cleared like the block at reset
    alu8080_pkg::alu_state_t alu_model = '0;
    alu_expect_t pending_results[$];
    alu_expect_t accepted_entry;
    alu_expect_t oldest_entry;

    int  mismatch_count   = 0;
    int  stall_cycles     = 0;
    int  items_sent       = 0;
    bit  sender_idles     = 1'b1;
    bit  receiver_idles   = 1'b1;
    bit  hold_off_request = 1'b0;

    alu_8080_immediate_flags uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .operand     (operand),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_byte (result_byte),
        .flag_byte   (flag_byte)
    );

    always #5 clk = ~clk;

    // works out the result of one command and advances the predictor state
    function automatic alu8080_pkg::alu_result_t predict_alu(input logic [2:0] cmd,
                                                             input logic [7:0] data);
        logic [8:0]               wide;
        logic [4:0]               nibble;
        logic [7:0]               szp_src;
        logic                     carry_in;
        alu8080_pkg::alu_result_t res;
        res.result_byte = alu_model.acc;
        szp_src         = alu_model.acc;
        case (cmd)
            alu8080_pkg::CMD_DCR:
            begin
                // accumulator and carry stay, ac means no borrow out of bit 3
                res.result_byte = data - 8'd1;
                szp_src         = res.result_byte;
                alu_model.ac    = (data[3:0] != 4'd0);
            end
            alu8080_pkg::CMD_ANI:
            begin
                alu_model.acc   = alu_model.acc & data;
                res.result_byte = alu_model.acc;
                szp_src         = alu_model.acc;
                alu_model.cy    = 1'b0;
                alu_model.ac    = 1'b0;
            end
            alu8080_pkg::CMD_ADI, alu8080_pkg::CMD_ACI:
            begin
                // carry-in only for add with carry, and it counts toward ac too
                carry_in        = (cmd == alu8080_pkg::CMD_ACI) ? alu_model.cy : 1'b0;
                wide            = {1'b0, alu_model.acc} + {1'b0, data} + {8'd0, carry_in};
                nibble          = {1'b0, alu_model.acc[3:0]} + {1'b0, data[3:0]}
                                + {4'd0, carry_in};
                alu_model.acc   = wide[7:0];
                res.result_byte = alu_model.acc;
                szp_src         = alu_model.acc;
                alu_model.cy    = wide[8];
                alu_model.ac    = nibble[4];
            end
            alu8080_pkg::CMD_CPI:
            begin
                // flags from the difference, accumulator untouched
                wide         = {1'b0, alu_model.acc} - {1'b0, data};
                nibble       = {1'b0, alu_model.acc[3:0]} - {1'b0, data[3:0]};
                szp_src      = wide[7:0];
                alu_model.cy = wide[8];
                alu_model.ac = nibble[4];
            end
            default:
            begin
                // unused codes change nothing
            end
        endcase
        if (cmd <= alu8080_pkg::CMD_CPI)
        begin
            alu_model.z = (szp_src == 8'h00);
            alu_model.s = szp_src[7];
            alu_model.p = ~^szp_src;
        end
        res.flag_byte                           = 8'h00;
        res.flag_byte[alu8080_pkg::FLAG_CY_BIT] = alu_model.cy;
        res.flag_byte[alu8080_pkg::FLAG_P_BIT]  = alu_model.p;
        res.flag_byte[alu8080_pkg::FLAG_AC_BIT] = alu_model.ac;
        res.flag_byte[alu8080_pkg::FLAG_Z_BIT]  = alu_model.z;
        res.flag_byte[alu8080_pkg::FLAG_S_BIT]  = alu_model.s;
        return res;
    endfunction

    // random byte with a bias toward the nibble and sign boundaries
    function automatic logic [7:0] random_operand();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 6))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h0F;
            3: return 8'h10;
            4: return 8'h7F;
            5: return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    // predict at every input transfer, using the values sampled before the edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            accepted_entry.cmd  = command;
            accepted_entry.data = operand;
            accepted_entry.res  = predict_alu(command, operand);
            pending_results.push_back(accepted_entry);
        end
    end

    // compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result result_byte=%02h flag_byte=%02h",
                             $time, result_byte, flag_byte);
            end
            else
            begin
                oldest_entry = pending_results.pop_front();
                if (result_byte !== oldest_entry.res.result_byte ||
                    flag_byte !== oldest_entry.res.flag_byte)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch cmd=%0d operand=%02h exp %02h/%02h got %02h/%02h",
                                 $time, oldest_entry.cmd, oldest_entry.data,
                                 oldest_entry.res.result_byte, oldest_entry.res.flag_byte,
                                 result_byte, flag_byte);
                end
            end
        end
    end

    // watchdog: too many cycles in a row without any transfer ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver side: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // offer one command and wait for its transfer; valid stays high on return
    task automatic send_command(input logic [2:0] cmd, input logic [7:0] data);
        int gap;
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        operand  <= data;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // one random command, a load then an equal compare, or a carry set-up then an add with carry
    task automatic send_random_command();
        int         pick;
        logic [7:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            value = random_operand();
            send_command(alu8080_pkg::CMD_ANI, 8'h00);
            send_command(alu8080_pkg::CMD_ADI, value);
            send_command(alu8080_pkg::CMD_CPI, value);
        end
        else if (pick < 14)
        begin
            // carry set up so that the add with carry sees a carry-in unless the accumulator was zero
            send_command(alu8080_pkg::CMD_ADI, 8'hFF);
            send_command(alu8080_pkg::CMD_ACI, random_operand());
        end
        else if (pick < 20)
            send_command(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                         random_operand());
        else
            send_command(3'($urandom_range(alu8080_pkg::CMD_DCR, alu8080_pkg::CMD_CPI)),
                         random_operand());
    endtask

    // boundaries of every command, unused codes and the carry-in into aux carry
    task automatic test_directed_cases();
        send_command(alu8080_pkg::CMD_CPI, 8'h00);   // compare equal right after reset
        send_command(alu8080_pkg::CMD_ADI, 8'hFF);
        send_command(alu8080_pkg::CMD_ADI, 8'h01);   // wrap to zero, carry and aux carry out
        send_command(alu8080_pkg::CMD_ACI, 8'h00);   // carry-in alone
        send_command(alu8080_pkg::CMD_ADI, 8'hFF);
        send_command(alu8080_pkg::CMD_ACI, 8'hFF);   // carry-in completes both carries
        send_command(alu8080_pkg::CMD_ACI, 8'h7F);   // carry-in pushes low nibble into sign
        send_command(alu8080_pkg::CMD_ANI, 8'hFF);   // and clears carry and aux carry
        send_command(alu8080_pkg::CMD_ANI, 8'h00);
        send_command(alu8080_pkg::CMD_DCR, 8'h00);   // decrement wraps, borrow out of bit 3
        send_command(alu8080_pkg::CMD_DCR, 8'h01);
        send_command(alu8080_pkg::CMD_DCR, 8'h10);
        send_command(alu8080_pkg::CMD_DCR, 8'hFF);
        send_command(alu8080_pkg::CMD_ADI, 8'h0F);
        send_command(alu8080_pkg::CMD_CPI, 8'h10);   // borrow out of bit 7 only
        send_command(alu8080_pkg::CMD_CPI, 8'h0F);
        send_command(alu8080_pkg::CMD_CPI, 8'h01);
        send_command(alu8080_pkg::CMD_ADI, 8'h71);
        send_command(alu8080_pkg::CMD_CPI, 8'h01);   // borrow out of bit 3 only
        send_command(alu8080_pkg::CMD_CPI, 8'hFF);
        send_command(alu8080_pkg::CMD_ACI, 8'h80);
        send_command(CMD_UNUSED_FIRST, 8'hFF);
        send_command(CMD_UNUSED_MID, 8'h00);
        send_command(CMD_UNUSED_LAST, 8'hA5);
    endtask

    task automatic test_random_traffic();
        int goal;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
            send_random_command();
    endtask

    // long receiver hold-off while the sender keeps offering, so in_ready drops
    task automatic test_output_backpressure();
        int goal;
        sender_idles     = 1'b0;
        hold_off_request = 1'b1;
        goal = items_sent + PRESSURE_ITEMS;
        while (items_sent < goal)
            send_random_command();
        sender_idles = 1'b1;
    endtask

    // sender sends a batch, goes quiet until every expected result has come back, then sends more
    task automatic test_drain_pause();
        int goal;
        goal = items_sent + PAUSE_ITEMS;
        while (items_sent < goal)
            send_random_command();
        in_valid <= 1'b0;
        // wait on a clock edge first so the last transfer is already in the queue
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        goal = items_sent + PAUSE_ITEMS;
        while (items_sent < goal)
            send_random_command();
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_full_rate();
        int goal;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        goal = items_sent + FULL_RATE_ITEMS;
        while (items_sent < goal)
            send_random_command();
    endtask

    initial
    begin
        // reset held low from the start and released at a clock edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();
        test_full_rate();
        in_valid <= 1'b0;
        // wait for the last results, then DRAIN_CYCLES more for strays
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== alu_8080_immediate_flags.f =====
hdl/alu8080_pkg.sv
hdl/alu8080_core.sv
hdl/alu_8080_immediate_flags.sv
dv/alu_8080_immediate_flags_test.sv
